@@ src/nnue_pkg.sv @@
// ---------------------------------------------------------------------------
// nnue_pkg: shared types and constants
// Command codes, beat layouts and fixed network constants for the NNUE
// accumulator evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package nnue_pkg;

    localparam int FEATURES = 768;
    localparam int KINDS    = 6;
    localparam int SQUARES  = 64;

    // Pieces above this code belong to black.
    localparam logic [3:0] LAST_WHITE_PIECE = 4'd5;
    localparam logic [3:0] LAST_PIECE       = 4'd11;

    localparam logic [9:0] BLACK_ROW_BASE = 10'(KINDS * SQUARES);

    localparam logic [26:0] SCORE_SCALE = 27'd100000000;

    localparam logic [2:0] CMD_LOAD_WEIGHT = 3'd0;
    localparam logic [2:0] CMD_LOAD_BIAS   = 3'd1;
    localparam logic [2:0] CMD_LOAD_OUTW   = 3'd2;
    localparam logic [2:0] CMD_CLEAR       = 3'd3;
    localparam logic [2:0] CMD_ADD         = 3'd4;
    localparam logic [2:0] CMD_REMOVE      = 3'd5;
    localparam logic [2:0] CMD_EVAL        = 3'd6;

    typedef struct packed {
        logic [2:0]         command;
        logic [9:0]         feature_index;
        logic [4:0]         neuron;
        logic signed [15:0] weight_value;
        logic [6:0]         square;
        logic [3:0]         piece;
        logic               white_view;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] score;
        logic               saturated;
    } res_t;

endpackage

`default_nettype wire

@@ src/nnue_accumulator_eval.sv @@
// ---------------------------------------------------------------------------
// nnue_accumulator_eval: incremental NNUE accumulator and evaluator
// Keeps HIDDEN saturating hidden sums over 768 piece-square features, loads
// the network weights and scores a position with a bias adder and a multiply-accumulate.
// ---------------------------------------------------------------------------
//
//  channel | direction | signals                  | handshake
//  --------+-----------+--------------------------+------------------------
//  cmd     | in        | cmd (cmd_t)              | cmd_valid / cmd_ready
//  res     | out       | res (res_t)              | res_valid / res_ready
//  cfg     | in        | cfg_wdata (output bias)  | cfg_wen, no wait
//
// Loads are written on acceptance and clear zeroes every hidden sum in turn. Add and remove
// walk one neuron per cycle through the sum memory read and write-back. Evaluate walks one
// neuron per cycle through the bias add, multiplier and accumulator, then three scaling
// steps. After reset a clearing pass zeroes the hidden sums while cmd_ready stays low. A
// waiting result beat does not block new commands, but a following evaluate holds in its
// last step until the slot is free.
//
`default_nettype none

module nnue_accumulator_eval
    import nnue_pkg::*;
#(
    parameter int HIDDEN = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire cmd_t               cmd,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output res_t                    res,
    input  wire logic               cfg_wen,
    input  wire logic signed [15:0] cfg_wdata
);

    localparam int H_W    = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int WDEPTH = FEATURES * HIDDEN;
    localparam int WA_W   = $clog2(WDEPTH);
    localparam int ACC_W  = 48 + H_W;

    localparam logic [H_W-1:0]        LAST_IDX = H_W'(HIDDEN - 1);
    localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(64'sd4294967296);
    localparam logic signed [ACC_W-1:0] LIM_NEG = ACC_W'(-64'sd4294967296);
    localparam logic [35:0] MAG_MAX_POS = 36'h0_7FFF_FFFF;
    localparam logic [35:0] MAG_MAX_NEG = 36'h0_8000_0000;
    localparam logic [35:0] MAG_OVR_NEG = 36'h0_8000_0001;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_UPD   = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_SCALE = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    // Memories.
    logic signed [15:0] wmem [WDEPTH];
    logic signed [15:0] bias_mem [HIDDEN];
    logic signed [15:0] outw_mem [HIDDEN];
    logic signed [31:0] sum_mem [HIDDEN];

    // Control registers.
    state_t          state_reg, state_next;
    logic [H_W-1:0]  idx_reg, idx_next;
    logic [WA_W-1:0] wptr_reg, wptr_next;
    logic            issue_reg, issue_next;
    logic            p1_v_reg, p1_v_next;
    logic            p2_v_reg, p2_v_next;
    logic            p3_v_reg, p3_v_next;
    logic            res_valid_reg, res_valid_next;
    logic signed [15:0] output_bias_reg;

    // Datapath registers.
    logic [H_W-1:0]     p1_idx_reg;
    logic               sub_reg, sub_next;
    logic               white_reg, white_next;
    logic signed [31:0] sum_rd_reg;
    logic signed [15:0] w_rd_reg;
    logic signed [15:0] bias_rd_reg;
    logic signed [15:0] ow_rd_reg;
    logic signed [31:0] act_reg;
    logic signed [15:0] ow_d_reg;
    logic signed [47:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic               neg_reg, big_pos_reg, big_neg_reg;
    logic [31:0]        abs_reg;
    logic [58:0]        scaled_reg;
    res_t               res_reg, res_next;

    // Decoded command fields.
    logic            accept;
    logic            row_ok;
    logic            side;
    logic [3:0]      kind;
    logic [9:0]      row;
    logic            load_w_we, load_b_we, load_o_we;
    logic            neuron_ok;
    logic [WA_W-1:0] load_waddr;

    logic               sum_we;
    logic [H_W-1:0]     sum_waddr;
    logic signed [31:0] sum_wdata;
    logic signed [32:0] upd_wide;
    logic signed [31:0] upd_sat;
    logic signed [32:0] act_wide;
    logic signed [31:0] act_sat;
    logic signed [ACC_W-1:0] acc_abs;
    logic [35:0]        mag;
    logic               neg_out;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign side      = (cmd.piece > LAST_WHITE_PIECE);
    assign kind      = side ? (cmd.piece - 4'(KINDS)) : cmd.piece;
    assign row       = (side ? BLACK_ROW_BASE : 10'd0)
                     + {1'b0, kind[2:0], cmd.square[6:4], cmd.square[2:0]};
    assign row_ok    = !cmd.square[3] && (cmd.piece <= LAST_PIECE);
    assign neuron_ok = (32'(cmd.neuron) < HIDDEN);
    assign load_waddr = WA_W'(cmd.feature_index) * WA_W'(HIDDEN) + WA_W'(cmd.neuron);

    assign load_w_we = accept && (cmd.command == CMD_LOAD_WEIGHT) && neuron_ok
                     && (32'(cmd.feature_index) < FEATURES);
    assign load_b_we = accept && (cmd.command == CMD_LOAD_BIAS) && neuron_ok;
    assign load_o_we = accept && (cmd.command == CMD_LOAD_OUTW) && neuron_ok;

    assign upd_wide = 33'(sum_rd_reg) + (sub_reg ? -33'(w_rd_reg) : 33'(w_rd_reg));
    assign upd_sat  = sat32(upd_wide);
    assign act_wide = 33'(sum_rd_reg) + 33'(bias_rd_reg);
    assign act_sat  = sat32(act_wide);

    // Hidden sum write port: zeros during a clearing pass, updates otherwise.
    always_comb
    begin
        sum_we    = 1'b0;
        sum_waddr = idx_reg;
        sum_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            sum_we = 1'b1;
        end
        else if ((state_reg == S_UPD) && p1_v_reg)
        begin
            sum_we    = 1'b1;
            sum_waddr = p1_idx_reg;
            sum_wdata = upd_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_w_we)
        begin
            wmem[load_waddr] <= cmd.weight_value;
        end
        w_rd_reg <= wmem[wptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_b_we)
        begin
            bias_mem[H_W'(cmd.neuron)] <= cmd.weight_value;
        end
        bias_rd_reg <= bias_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_o_we)
        begin
            outw_mem[H_W'(cmd.neuron)] <= cmd.weight_value;
        end
        ow_rd_reg <= outw_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[idx_reg];
    end

    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;

    always_comb
    begin
        if (big_pos_reg)
        begin
            mag = MAG_MAX_NEG;
        end
        else if (big_neg_reg)
        begin
            mag = MAG_OVR_NEG;
        end
        else
        begin
            mag = {1'b0, scaled_reg[58:24]};
        end
    end

    // Black's view flips the sign before the score is clipped to 32 bits.
    assign neg_out = neg_reg ^ !white_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        wptr_next      = wptr_reg;
        issue_next     = issue_reg;
        sub_next       = sub_reg;
        white_next     = white_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        p1_v_next      = 1'b0;
        p2_v_next      = 1'b0;
        p3_v_next      = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command) inside
                        CMD_CLEAR:
                        begin
                            state_next = S_CLEAR;
                            idx_next   = '0;
                        end
                        CMD_ADD, CMD_REMOVE:
                        begin
                            if (row_ok)
                            begin
                                state_next = S_UPD;
                                idx_next   = '0;
                                issue_next = 1'b1;
                                wptr_next  = WA_W'(row) * WA_W'(HIDDEN);
                                sub_next   = (cmd.command == CMD_REMOVE);
                            end
                        end
                        CMD_EVAL:
                        begin
                            state_next = S_EVAL;
                            idx_next   = '0;
                            issue_next = 1'b1;
                            white_next = cmd.white_view;
                            acc_next   = ACC_W'($signed({output_bias_reg, 12'b0}));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_UPD, S_EVAL:
            begin
                p1_v_next = issue_reg;
                p2_v_next = p1_v_reg && (state_reg == S_EVAL);
                p3_v_next = p2_v_reg;
                if (p3_v_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (issue_reg)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        wptr_next = wptr_reg + 1'b1;
                    end
                end
                else if (!p1_v_reg && !p2_v_reg && !p3_v_reg)
                begin
                    state_next = (state_reg == S_EVAL) ? S_SCALE : S_IDLE;
                end
            end
            S_SCALE:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (neg_out)
                    begin
                        res_next.saturated = (mag > MAG_MAX_NEG);
                        res_next.score     = (mag > MAG_MAX_NEG) ? 32'sh8000_0000
                                                                 : -$signed(mag[31:0]);
                    end
                    else
                    begin
                        res_next.saturated = (mag > MAG_MAX_POS);
                        res_next.score     = (mag > MAG_MAX_POS) ? 32'sh7FFF_FFFF
                                                                 : $signed(mag[31:0]);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            idx_reg         <= '0;
            wptr_reg        <= '0;
            issue_reg       <= 1'b0;
            p1_v_reg        <= 1'b0;
            p2_v_reg        <= 1'b0;
            p3_v_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
            output_bias_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            wptr_reg      <= wptr_next;
            issue_reg     <= issue_next;
            p1_v_reg      <= p1_v_next;
            p2_v_reg      <= p2_v_next;
            p3_v_reg      <= p3_v_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wen)
            begin
                output_bias_reg <= cfg_wdata;
            end
        end
    end

    // Datapath stages; the valid bits above qualify them.
    always_ff @(posedge clk)
    begin
        p1_idx_reg <= idx_reg;
        sub_reg    <= sub_next;
        white_reg  <= white_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        act_reg    <= act_sat[31] ? 32'sd0 : act_sat;
        ow_d_reg   <= ow_rd_reg;
        prod_reg   <= act_reg * ow_d_reg;
        if (state_reg == S_SCALE)
        begin
            neg_reg     <= acc_reg[ACC_W-1];
            big_pos_reg <= (acc_reg >= LIM_POS);
            big_neg_reg <= (acc_reg <= LIM_NEG);
            abs_reg     <= acc_abs[31:0];
        end
        if (state_reg == S_MUL)
        begin
            scaled_reg <= 59'(abs_reg) * 59'(SCORE_SCALE);
        end
    end

    // A result beat only ever comes out of the final scaling step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output step");

    // Stage data is only live while a neuron walk is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (p1_v_reg || p2_v_reg || p3_v_reg) |-> (state_reg == S_UPD || state_reg == S_EVAL))
        else $error("walk pipeline active outside a walk");

    // A clearing pass ends only after the last neuron was zeroed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && (state_next != S_CLEAR) |-> (idx_reg == LAST_IDX))
        else $error("clearing pass ended early");

    // Commands are never taken while a walk still issues reads.
    assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg |-> !cmd_ready)
        else $error("command accepted during a neuron walk");

endmodule

`default_nettype wire

@@ test/nnue_accumulator_eval_tb.sv @@
// ---------------------------------------------------------------------------
// nnue_accumulator_eval_tb: self-checking bench for the NNUE evaluator
// Streams load, clear, add, remove and evaluate commands into the block while
// a shadow network predicts every score. The scores coming back are compared
// field by field. The bench runs in phases with tame and wide weight sets and
// several output bias settings, and outside one calm phase both sides stall at random.
// ---------------------------------------------------------------------------
`default_nettype none

module nnue_accumulator_eval_tb;

    import nnue_pkg::*;

    localparam int HIDDEN      = 32;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam longint ACC_SPAN = 64'sd4294967296;
    localparam longint Q24_ONE  = 64'sd16777216;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    cmd_t               cmd       = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    res_t               res;
    logic               cfg_wen   = 1'b0;
    logic signed [15:0] cfg_wdata = '0;

    // Shadow copy of the network.
    logic signed [15:0] layer1_w [FEATURES*HIDDEN];
    logic signed [15:0] hid_bias [HIDDEN];
    logic signed [15:0] out_w    [HIDDEN];
    logic signed [31:0] hid_sum  [HIDDEN] = '{default: '0};
    logic signed [15:0] out_bias = '0;

    cmd_t        pending   [$];
    res_t        score_due [$];
    logic [10:0] placed    [$];
    bit          row_full  [FEATURES] = '{default: 1'b0};

    bit cmd_taken;
    bit calm;
    int wide_pct;
    int work_items;
    int cycle_count;
    int commands_done;
    int scores_checked;
    int scores_clipped;
    int bias_writes;
    int errors;

    nnue_accumulator_eval #(
        .HIDDEN(HIDDEN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int feature_row(logic [3:0] pc, logic [6:0] sq);
        int side;
        side = (pc > LAST_WHITE_PIECE) ? 1 : 0;
        return side*KINDS*SQUARES + SQUARES*(int'(pc) - KINDS*side)
               + 8*int'(sq[6:4]) + int'(sq[2:0]);
    endfunction

    function automatic longint clip32(longint v, output bit hit);
        hit = (v > WORD_MAX) || (v < WORD_MIN);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    function automatic res_t predict_score(logic white);
        longint acc;
        longint act;
        longint val;
        bit     hit;
        bit     clipped;
        res_t   r;
        acc = longint'(out_bias) * 4096;
        for (int i = 0; i < HIDDEN; i++)
        begin
            act = clip32(longint'(hid_sum[i]) + longint'(hid_bias[i]), hit);
            if (act < 0)
                act = 0;
            acc += act * longint'(out_w[i]);
        end
        // Beyond this span the scaled score is out of range either way.
        if (acc >= ACC_SPAN)
            val = WORD_MAX + 1;
        else if (acc <= -ACC_SPAN)
            val = WORD_MIN - 1;
        else
            val = acc * longint'(SCORE_SCALE) / Q24_ONE;
        if (!white)
            val = -val;
        val = clip32(val, clipped);
        r.score     = val[31:0];
        r.saturated = clipped;
        return r;
    endfunction

    function automatic void apply_command(cmd_t c);
        int     row;
        longint w;
        longint s;
        bit     hit;
        case (c.command) inside
            CMD_LOAD_WEIGHT:
                if (c.feature_index < FEATURES && c.neuron < HIDDEN)
                    layer1_w[int'(c.feature_index)*HIDDEN + int'(c.neuron)] = c.weight_value;
            CMD_LOAD_BIAS:
                if (c.neuron < HIDDEN)
                    hid_bias[c.neuron] = c.weight_value;
            CMD_LOAD_OUTW:
                if (c.neuron < HIDDEN)
                    out_w[c.neuron] = c.weight_value;
            CMD_CLEAR:
                hid_sum = '{default: '0};
            CMD_ADD, CMD_REMOVE:
                if (!c.square[3] && c.piece <= LAST_PIECE)
                begin
                    row = feature_row(c.piece, c.square);
                    for (int i = 0; i < HIDDEN; i++)
                    begin
                        w = layer1_w[row*HIDDEN + i];
                        s = longint'(hid_sum[i]) + ((c.command == CMD_ADD) ? w : -w);
                        hid_sum[i] = 32'(clip32(s, hit));
                    end
                end
            CMD_EVAL:
                score_due.push_back(predict_score(c.white_view));
            default:
                ;
        endcase
    endfunction

    // Command driver: a beat holds until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= calm || ($urandom_range(99) >= 7);
            if (!cmd_valid || cmd_taken)
            begin
                if (pending.size() != 0 && (calm || $urandom_range(99) >= 7))
                begin
                    cmd       <= pending.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // Monitor: updates the shadow network and checks score beats.
    always @(posedge clk)
    begin : monitor
        res_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                if (cfg_wen)
                begin
                    out_bias = cfg_wdata;
                    bias_writes++;
                end
                cmd_taken = cmd_valid && cmd_ready;
                if (cmd_taken)
                begin
                    apply_command(cmd);
                    commands_done++;
                end
                if (res_valid && res_ready)
                begin
                    if (score_due.size() == 0)
                    begin
                        $error("score beat with no evaluation waiting: score %0d", res.score);
                        errors++;
                    end
                    else
                    begin
                        want = score_due.pop_front();
                        scores_checked++;
                        if (want.saturated)
                            scores_clipped++;
                        if (res.score !== want.score)
                        begin
                            $error("score: expected %0d, got %0d", want.score, res.score);
                            errors++;
                        end
                        if (res.saturated !== want.saturated)
                        begin
                            $error("saturated: expected %0b, got %0b",
                                   want.saturated, res.saturated);
                            errors++;
                        end
                    end
                end
            end
        end
    end

    function automatic cmd_t random_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(cmd_t)-1:0];
    endfunction

    function automatic logic signed [15:0] rand_q412();
        if ($urandom_range(99) < wide_pct)
            return 16'($urandom);
        return 16'($urandom_range(255) - 128);
    endfunction

    task automatic send(cmd_t c, bit counted);
        pending.push_back(c);
        if (counted)
            work_items++;
    endtask

    task automatic load(logic [2:0] op, int feat, int nrn, logic signed [15:0] v);
        cmd_t c;
        c               = random_fields();
        c.command       = op;
        c.feature_index = feat[9:0];
        c.neuron        = nrn[4:0];
        c.weight_value  = v;
        send(c, op != CMD_LOAD_WEIGHT || feat < FEATURES);
    endtask

    task automatic place(logic [2:0] op, logic [3:0] pc, logic [6:0] sq);
        cmd_t c;
        c         = random_fields();
        c.command = op;
        c.piece   = pc;
        c.square  = sq;
        send(c, !sq[3] && pc <= LAST_PIECE);
    endtask

    task automatic issue(logic [2:0] op, logic white);
        cmd_t c;
        c            = random_fields();
        c.command    = op;
        c.white_view = white;
        send(c, op != CMD_UNUSED);
    endtask

    // Writes a whole weight row so that adds and removes never touch an
    // entry that was never loaded.
    task automatic load_row(logic [3:0] pc, logic [6:0] sq, bit extreme);
        int row;
        row = feature_row(pc, sq);
        for (int n = 0; n < HIDDEN; n++)
            load(CMD_LOAD_WEIGHT, row, n,
                 extreme ? ((n % 2 != 0) ? 16'sh8000 : 16'sh7fff) : rand_q412());
        row_full[row] = 1'b1;
        placed.push_back({pc, sq});
    endtask

    task automatic reload_network();
        for (int n = 0; n < HIDDEN; n++)
        begin
            load(CMD_LOAD_BIAS, $urandom_range(1023), n, rand_q412());
            load(CMD_LOAD_OUTW, $urandom_range(1023), n, rand_q412());
        end
        issue(CMD_CLEAR, 1'b0);
        row_full = '{default: 1'b0};
        placed.delete();
    endtask

    task automatic pick_placement(output logic [3:0] pc, output logic [6:0] sq);
        if (placed.size() == 0 || $urandom_range(99) < 3)
        begin
            pc = 4'($urandom_range(11));
            sq = {3'($urandom_range(7)), 1'b0, 3'($urandom_range(7))};
            if (!row_full[feature_row(pc, sq)])
                load_row(pc, sq, 1'b0);
        end
        else
            {pc, sq} = placed[$urandom_range(placed.size() - 1)];
    endtask

    task automatic random_commands(int quota);
        int          goal;
        int          pick;
        logic [3:0]  pc;
        logic [6:0]  sq;
        logic [10:0] spot;
        goal = work_items + quota;
        while (work_items < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                pick_placement(pc, sq);
                place((pick < 30) ? CMD_ADD : CMD_REMOVE, pc, sq);
            end
            else if (pick < 70)
                issue(CMD_EVAL, 1'($urandom_range(1)));
            else if (pick < 74)
                issue(CMD_CLEAR, 1'($urandom_range(1)));
            else if (pick < 82)
            begin
                if (placed.size() != 0 && pick < 79)
                begin
                    spot = placed[$urandom_range(placed.size() - 1)];
                    load(CMD_LOAD_WEIGHT, feature_row(spot[10:7], spot[6:0]),
                         $urandom_range(HIDDEN - 1), rand_q412());
                end
                else
                    load(CMD_LOAD_WEIGHT, $urandom_range(1023, FEATURES),
                         $urandom_range(31), 16'($urandom));
            end
            else if (pick < 88)
                load(CMD_LOAD_BIAS, $urandom_range(1023), $urandom_range(HIDDEN - 1),
                     rand_q412());
            else if (pick < 94)
                load(CMD_LOAD_OUTW, $urandom_range(1023), $urandom_range(HIDDEN - 1),
                     rand_q412());
            else if (pick < 96)
                issue(CMD_UNUSED, 1'($urandom_range(1)));
            else if (pick < 98)
                place(($urandom_range(1) != 0) ? CMD_ADD : CMD_REMOVE,
                      4'($urandom_range(11)), 7'($urandom) | 7'h08);
            else
                place(($urandom_range(1) != 0) ? CMD_ADD : CMD_REMOVE,
                      4'($urandom_range(15, 12)), 7'($urandom));
        end
    endtask

    // Holds off until every beat is taken and every score is back, then lets
    // the block finish any add or remove still walking the neurons.
    task automatic wait_quiet();
        while (pending.size() != 0 || cmd_valid || score_due.size() != 0)
            @(posedge clk);
        repeat (HIDDEN + 12) @(posedge clk);
    endtask

    task automatic write_out_bias(logic signed [15:0] v);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic signed [15:0] bias_plan [5];
        int                 wide_plan [5];
        bias_plan = '{16'($urandom), 16'sh7fff, 16'sh8000, 16'sh0000, 16'($urandom)};
        wide_plan = '{3, 3, 40, 3, 12};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 5; p++)
        begin
            wait_quiet();
            write_out_bias(bias_plan[p]);
            wide_pct = wide_plan[p];
            calm     = (p == 3);
            if (p != 1 && p != 4)
                reload_network();
            if (p == 0)
            begin
                load_row(4'd0, 7'h00, 1'b1);
                load_row(LAST_PIECE, 7'h77, 1'b1);
                load(CMD_LOAD_WEIGHT, FEATURES, HIDDEN - 1, 16'sh7fff);
                load(CMD_LOAD_WEIGHT, 1023, 0, 16'sh8000);
                place(CMD_ADD, 4'd0, 7'h00);
                place(CMD_ADD, LAST_PIECE, 7'h77);
                issue(CMD_EVAL, 1'b1);
                issue(CMD_EVAL, 1'b0);
                place(CMD_REMOVE, 4'd0, 7'h00);
                issue(CMD_EVAL, 1'b1);
                place(CMD_ADD, 4'd0, 7'h08);
                place(CMD_REMOVE, LAST_PIECE, 7'h7f);
                place(CMD_ADD, 4'd12, 7'h00);
                place(CMD_REMOVE, 4'd15, 7'h77);
                issue(CMD_UNUSED, 1'b1);
                // Large bias and output weight on one neuron push the score
                // past 32 bits in both directions.
                load(CMD_LOAD_BIAS, 0, 0, 16'sh7fff);
                load(CMD_LOAD_OUTW, 0, 0, 16'sh7fff);
                place(CMD_ADD, 4'd0, 7'h00);
                issue(CMD_EVAL, 1'b1);
                issue(CMD_EVAL, 1'b0);
                load(CMD_LOAD_OUTW, 0, 0, 16'sh8000);
                issue(CMD_EVAL, 1'b1);
                issue(CMD_EVAL, 1'b0);
                load(CMD_LOAD_BIAS, 0, 0, 16'sh8000);
                load(CMD_LOAD_OUTW, 0, 0, rand_q412());
                issue(CMD_CLEAR, 1'b1);
                issue(CMD_EVAL, 1'b0);
            end
            random_commands(210);
        end
        wait_quiet();
        $display("Covered %0d commands and %0d scores, %0d of them clipped to 32 bits.",
                 commands_done, scores_checked, scores_clipped);
        $display("Output bias took %0d settings, with tame and wide weight sets.",
                 bias_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
